/* hdl/euler_to_quaternion_defines.svh */
// Assertion macros shared by the euler_to_quaternion RTL.
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define E2Q_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define E2Q_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/e2q_pkg.sv */
// Shared types, constants and tables of the Euler angle to quaternion converter.
package e2q_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned WORK_FRAC      = 30;
  localparam int unsigned CORDIC_STEPS   = 30;
  localparam int unsigned CW             = 34;  // CORDIC datapath width
  localparam int unsigned PW             = 32;  // sine, cosine and product width
  localparam int unsigned QW             = 33;  // unnormalized component width
  localparam int unsigned ORDER_BITS     = 3;
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam logic signed [CW-1:0] CORDIC_X0 = CW'(652032874);

  typedef enum logic [ORDER_BITS-1:0] {
    ORD_XYZ = 3'd0,
    ORD_YXZ = 3'd1,
    ORD_ZXY = 3'd2,
    ORD_ZYX = 3'd3,
    ORD_YZX = 3'd4,
    ORD_XZY = 3'd5
  } order_e;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
    logic signed [QW-1:0] w;
  } quat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // atan(2^-i) with pi at 2^31
  function automatic logic signed [CW-1:0] atan_entry(input int i);
    logic signed [CW-1:0] r;
    case (i)
      0:  r = CW'(536870912);
      1:  r = CW'(316933406);
      2:  r = CW'(167458907);
      3:  r = CW'(85004756);
      4:  r = CW'(42667331);
      5:  r = CW'(21354465);
      6:  r = CW'(10680862);
      7:  r = CW'(5340245);
      8:  r = CW'(2670163);
      9:  r = CW'(1335087);
      10: r = CW'(667544);
      11: r = CW'(333772);
      12: r = CW'(166886);
      13: r = CW'(83443);
      14: r = CW'(41722);
      15: r = CW'(20861);
      16: r = CW'(10430);
      17: r = CW'(5215);
      18: r = CW'(2608);
      19: r = CW'(1304);
      20: r = CW'(652);
      21: r = CW'(326);
      22: r = CW'(163);
      23: r = CW'(81);
      24: r = CW'(41);
      25: r = CW'(20);
      26: r = CW'(10);
      27: r = CW'(5);
      28: r = CW'(3);
      29: r = CW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Negate flags of the second term, {x, y, z, w}
  function automatic logic [3:0] order_neg(input logic [ORDER_BITS-1:0] code);
    logic [3:0] r;
    case (order_e'(code))
      ORD_XYZ: r = 4'b0101;
      ORD_YXZ: r = 4'b0110;
      ORD_ZXY: r = 4'b1001;
      ORD_ZYX: r = 4'b1010;
      ORD_YZX: r = 4'b0011;
      ORD_XZY: r = 4'b1100;
      default: r = 4'b0101;
    endcase
    return r;
  endfunction

endpackage

/* hdl/e2q_front.sv */
// Front pipeline: half angles, three CORDIC lanes and the quaternion products.
module e2q_front #(
  parameter int unsigned ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                in_valid_i,
  input  logic signed [ANGLE_BITS-1:0]        angle_x_i,
  input  logic signed [ANGLE_BITS-1:0]        angle_y_i,
  input  logic signed [ANGLE_BITS-1:0]        angle_z_i,
  input  logic [e2q_pkg::ORDER_BITS-1:0]      order_i,
  output logic                                valid_o,
  output e2q_pkg::quat_t                      quat_o
);

  localparam int unsigned NS = e2q_pkg::CORDIC_STEPS;
  localparam int unsigned FL = NS + 4;
  localparam int unsigned CW = e2q_pkg::CW;
  localparam int unsigned PW = e2q_pkg::PW;
  localparam int unsigned QW = e2q_pkg::QW;

  logic [FL-1:0] v_q;

  logic signed [CW-1:0] cx_q [NS+1][3];
  logic signed [CW-1:0] cy_q [NS+1][3];
  logic signed [CW-1:0] cz_q [NS+1][3];
  logic signed [CW-1:0] cx_d [NS+1][3];
  logic signed [CW-1:0] cy_d [NS+1][3];
  logic signed [CW-1:0] cz_d [NS+1][3];

  logic signed [PW-1:0] pr_q [4];
  logic signed [PW-1:0] pr_d [4];
  logic signed [PW-1:0] s3_q, c3_q;
  logic signed [PW-1:0] tr_q [8];
  logic signed [PW-1:0] tr_d [8];
  e2q_pkg::quat_t       sum_q, sum_d;

  logic signed [ANGLE_BITS-1:0] ang [3];
  logic [31:0]                  ph  [3];
  logic signed [PW-1:0]         sn  [3];
  logic signed [PW-1:0]         cs  [3];
  logic [3:0]                   neg;

  // Rounded Q30 product
  function automatic logic signed [PW-1:0] qmul(input logic signed [PW-1:0] a,
                                                input logic signed [PW-1:0] b);
    logic signed [2*PW-1:0] p;
    p = a * b;
    p = p + ((2*PW)'(1) << (e2q_pkg::WORK_FRAC - 1));
    return PW'(p >>> e2q_pkg::WORK_FRAC);
  endfunction

  assign ang[0] = angle_x_i;
  assign ang[1] = angle_y_i;
  assign ang[2] = angle_z_i;
  assign neg    = e2q_pkg::order_neg(order_i);

  // Phase load and CORDIC micro-rotations
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ph[l]      = 32'(ang[l]) << (32 - ANGLE_BITS);
      cx_d[0][l] = e2q_pkg::CORDIC_X0;
      cy_d[0][l] = '0;
      cz_d[0][l] = CW'($signed(ph[l]) >>> 1);
    end
    for (int s = 1; s <= NS; s++) begin
      for (int l = 0; l < 3; l++) begin
        if (!cz_q[s-1][l][CW-1]) begin
          cx_d[s][l] = cx_q[s-1][l] - (cy_q[s-1][l] >>> (s - 1));
          cy_d[s][l] = cy_q[s-1][l] + (cx_q[s-1][l] >>> (s - 1));
          cz_d[s][l] = cz_q[s-1][l] - e2q_pkg::atan_entry(s - 1);
        end else begin
          cx_d[s][l] = cx_q[s-1][l] + (cy_q[s-1][l] >>> (s - 1));
          cy_d[s][l] = cy_q[s-1][l] - (cx_q[s-1][l] >>> (s - 1));
          cz_d[s][l] = cz_q[s-1][l] + e2q_pkg::atan_entry(s - 1);
        end
      end
    end
  end

  // Pair products, triple products and signed sums
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sn[l] = PW'(cy_q[NS][l]);
      cs[l] = PW'(cx_q[NS][l]);
    end
    pr_d[0] = qmul(sn[0], cs[1]);
    pr_d[1] = qmul(cs[0], sn[1]);
    pr_d[2] = qmul(cs[0], cs[1]);
    pr_d[3] = qmul(sn[0], sn[1]);
    tr_d[0] = qmul(pr_q[0], c3_q);
    tr_d[1] = qmul(pr_q[1], s3_q);
    tr_d[2] = qmul(pr_q[1], c3_q);
    tr_d[3] = qmul(pr_q[0], s3_q);
    tr_d[4] = qmul(pr_q[2], s3_q);
    tr_d[5] = qmul(pr_q[3], c3_q);
    tr_d[6] = qmul(pr_q[2], c3_q);
    tr_d[7] = qmul(pr_q[3], s3_q);
    sum_d.x = neg[3] ? QW'(tr_q[0]) - QW'(tr_q[1]) : QW'(tr_q[0]) + QW'(tr_q[1]);
    sum_d.y = neg[2] ? QW'(tr_q[2]) - QW'(tr_q[3]) : QW'(tr_q[2]) + QW'(tr_q[3]);
    sum_d.z = neg[1] ? QW'(tr_q[4]) - QW'(tr_q[5]) : QW'(tr_q[4]) + QW'(tr_q[5]);
    sum_d.w = neg[0] ? QW'(tr_q[6]) - QW'(tr_q[7]) : QW'(tr_q[6]) + QW'(tr_q[7]);
  end

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[FL-2:0], in_valid_i};
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q  <= cx_d;
      cy_q  <= cy_d;
      cz_q  <= cz_d;
      pr_q  <= pr_d;
      s3_q  <= sn[2];
      c3_q  <= cs[2];
      tr_q  <= tr_d;
      sum_q <= sum_d;
    end
  end

  assign valid_o = v_q[FL-1];
  assign quat_o  = sum_q;

endmodule

/* hdl/e2q_queue.sv */
// Short queue of unnormalized quaternions between front and back pipelines.
module e2q_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  e2q_pkg::quat_t       data_i,
  input  logic                 pop_i,
  output e2q_pkg::quat_t       data_o,
  output e2q_pkg::queue_stat_t stat_o
);

  localparam int unsigned DEPTH = e2q_pkg::QUEUE_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNTW  = AW + 1;

  e2q_pkg::quat_t  mem_q [DEPTH];
  logic [AW-1:0]   wr_q, rd_q;
  logic [CNTW-1:0] cnt_q;

  // Store pushed entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNTW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

  assign data_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CNTW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

/* hdl/e2q_back.sv */
// Back pipeline: sum of squares, square root, division, rounding and output register.
module e2q_back #(
  parameter int unsigned FRAC_BITS = e2q_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        head_valid_i,
  input  e2q_pkg::quat_t              head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [FRAC_BITS+1:0] quat_x_o,
  output logic signed [FRAC_BITS+1:0] quat_y_o,
  output logic signed [FRAC_BITS+1:0] quat_z_o,
  output logic signed [FRAC_BITS+1:0] quat_w_o
);

  localparam int unsigned QW  = e2q_pkg::QW;
  localparam int unsigned MW  = 32;
  localparam int unsigned SW  = 2 * MW;
  localparam int unsigned RS  = SW / 2;              // square root steps
  localparam int unsigned DS  = FRAC_BITS + 2;       // quotient bits
  localparam int unsigned NW  = MW + FRAC_BITS + 1;  // dividend width
  localparam int unsigned RW  = QW + 1;
  localparam int unsigned SH  = e2q_pkg::WORK_FRAC - FRAC_BITS;
  localparam int unsigned SDV = RS + 3;              // first division stage
  localparam int unsigned BL  = SDV + DS + 1;
  localparam int unsigned OW  = FRAC_BITS + 2;
  localparam logic signed [RW-1:0] ONE_S  = RW'(1) << FRAC_BITS;
  localparam logic signed [RW-1:0] MONE_S = -ONE_S;
  localparam logic [DS-1:0]        ONE_U  = DS'(1) << FRAC_BITS;

  logic en;
  logic [BL-1:0] v_q;
  logic          out_valid_q;

  logic signed [QW-1:0] hq [4];
  logic signed [QW-1:0] q_q [BL][4];
  logic signed [QW-1:0] q_d [BL][4];
  logic [MW-1:0]        m_q [SDV][4];
  logic [MW-1:0]        m_d [SDV][4];
  logic [SW-1:0]        sq_q [4];
  logic [SW-1:0]        sq_d [4];
  logic [SW-1:0]        rem_q [RS+1];
  logic [SW-1:0]        rem_d [RS+1];
  logic [SW-1:0]        res_q [RS+1];
  logic [SW-1:0]        res_d [RS+1];
  logic [NW-1:0]        dr_q [DS+1][4];
  logic [NW-1:0]        dr_d [DS+1][4];
  logic [DS-1:0]        quo_q [DS+1][4];
  logic [DS-1:0]        quo_d [DS+1][4];
  logic [MW-1:0]        dl_q [DS+1];
  logic [MW-1:0]        dl_d [DS+1];
  logic                 dz_q [DS+1];
  logic                 dz_d [DS+1];

  logic [SW-1:0]        trial [RS];
  logic [NW-1:0]        sub   [DS][4];
  logic [MW-1:0]        len;
  logic [DS-1:0]        dmag  [4];
  logic signed [RW-1:0] rn    [4];
  logic signed [RW-1:0] rz    [4];
  logic signed [RW-1:0] rr    [4];
  logic signed [OW-1:0] res_out [4];
  logic signed [OW-1:0] out_q   [4];

  // The back end moves whenever the output register can take a value
  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && head_valid_i;

  assign hq[0] = head_i.x;
  assign hq[1] = head_i.y;
  assign hq[2] = head_i.z;
  assign hq[3] = head_i.w;

  // Magnitudes, squares and carried components
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      q_d[0][l] = hq[l];
      m_d[0][l] = MW'(hq[l][QW-1] ? -hq[l] : hq[l]);
      sq_d[l]   = m_q[0][l] * m_q[0][l];
    end
    for (int s = 1; s < BL; s++) begin
      for (int l = 0; l < 4; l++) begin
        q_d[s][l] = q_q[s-1][l];
      end
    end
    for (int s = 1; s < SDV; s++) begin
      for (int l = 0; l < 4; l++) begin
        m_d[s][l] = m_q[s-1][l];
      end
    end
  end

  // Sum of squares, then square root, one result bit per stage
  always_comb begin
    rem_d[0] = sq_q[0] + sq_q[1] + sq_q[2] + sq_q[3];
    res_d[0] = '0;
    for (int k = 0; k < RS; k++) begin
      trial[k] = res_q[k] + (SW'(1) << (SW - 2 - 2 * k));
      if (rem_q[k] >= trial[k]) begin
        rem_d[k+1] = rem_q[k] - trial[k];
        res_d[k+1] = (res_q[k] >> 1) + (SW'(1) << (SW - 2 - 2 * k));
      end else begin
        rem_d[k+1] = rem_q[k];
        res_d[k+1] = res_q[k] >> 1;
      end
    end
  end

  // Rounded division by the length, one quotient bit per stage
  always_comb begin
    len     = res_q[RS][MW-1:0];
    dl_d[0] = len;
    dz_d[0] = (len == '0);
    for (int l = 0; l < 4; l++) begin
      dr_d[0][l]  = (NW'(m_q[SDV-1][l]) << FRAC_BITS) + NW'(len >> 1);
      quo_d[0][l] = '0;
    end
    for (int t = 0; t < DS; t++) begin
      dl_d[t+1] = dl_q[t];
      dz_d[t+1] = dz_q[t];
      for (int l = 0; l < 4; l++) begin
        sub[t][l] = NW'(dl_q[t]) << (DS - 1 - t);
        if (dr_q[t][l] >= sub[t][l]) begin
          dr_d[t+1][l]  = dr_q[t][l] - sub[t][l];
          quo_d[t+1][l] = {quo_q[t][l][DS-2:0], 1'b1};
        end else begin
          dr_d[t+1][l]  = dr_q[t][l];
          quo_d[t+1][l] = {quo_q[t][l][DS-2:0], 1'b0};
        end
      end
    end
  end

  // Pass-through rounding for a zero length
  if (SH == 0) begin : g_no_round
    always_comb begin
      for (int l = 0; l < 4; l++) begin
        rz[l] = RW'(q_q[BL-1][l]);
      end
    end
  end else begin : g_round
    logic signed [RW-1:0] rsum [4];
    always_comb begin
      for (int l = 0; l < 4; l++) begin
        rsum[l] = RW'(q_q[BL-1][l]) + (RW'(1) << (SH - 1));
        rz[l]   = rsum[l] >>> SH;
      end
    end
  end

  // Apply sign, pick path and clamp to plus or minus one
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      dmag[l] = (quo_q[DS][l] > ONE_U) ? ONE_U : quo_q[DS][l];
      rn[l]   = q_q[BL-1][l][QW-1] ? -RW'(dmag[l]) : RW'(dmag[l]);
      rr[l]   = dz_q[DS] ? rz[l] : rn[l];
      if (rr[l] > ONE_S) begin
        res_out[l] = OW'(ONE_S);
      end else if (rr[l] < MONE_S) begin
        res_out[l] = OW'(MONE_S);
      end else begin
        res_out[l] = OW'(rr[l]);
      end
    end
  end

  // Advance valid flags and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[BL-2:0], pop_o};
      out_valid_q <= v_q[BL-1];
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      q_q   <= q_d;
      m_q   <= m_d;
      sq_q  <= sq_d;
      rem_q <= rem_d;
      res_q <= res_d;
      dr_q  <= dr_d;
      quo_q <= quo_d;
      dl_q  <= dl_d;
      dz_q  <= dz_d;
      out_q <= res_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign quat_x_o    = out_q[0];
  assign quat_y_o    = out_q[1];
  assign quat_z_o    = out_q[2];
  assign quat_w_o    = out_q[3];

endmodule

/* hdl/euler_to_quaternion.sv */
// Top level of the Euler angle to unit quaternion converter.
//
//   channel   direction  handshake                 payload
//   cfg       in         cfg_valid_i / cfg_ready_o  cfg_data_i (rotation order)
//   in        in         in_valid_i / in_stall_o    angle_x_i, angle_y_i, angle_z_i
//   out       out        out_valid_o / out_stall_i  quat_x_o, quat_y_o, quat_z_o, quat_w_o
//
// One transaction per clock in both directions unless stalled; the pipeline depth is
// set by the 30 CORDIC stages, the 32 square root stages and FRAC_BITS + 2 divider stages.
// The front pipeline runs while the four-entry queue has room; the back pipeline and its
// output register hold while the output is stalled, so each side stalls on its own.
// Reset clears the rotation order to XYZ and empties every pipeline and the queue.
`include "euler_to_quaternion_defines.svh"

module euler_to_quaternion #(
  parameter int unsigned ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF,
  parameter int unsigned FRAC_BITS  = e2q_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [e2q_pkg::ORDER_BITS-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [ANGLE_BITS-1:0]     angle_x_i,
  input  logic signed [ANGLE_BITS-1:0]     angle_y_i,
  input  logic signed [ANGLE_BITS-1:0]     angle_z_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [FRAC_BITS+1:0]      quat_x_o,
  output logic signed [FRAC_BITS+1:0]      quat_y_o,
  output logic signed [FRAC_BITS+1:0]      quat_z_o,
  output logic signed [FRAC_BITS+1:0]      quat_w_o
);

  logic [e2q_pkg::ORDER_BITS-1:0] order_q;
  logic                           front_en;
  logic                           front_valid;
  e2q_pkg::quat_t                 front_quat;
  e2q_pkg::quat_t                 head_quat;
  e2q_pkg::queue_stat_t           q_stat;
  logic                           q_push;
  logic                           q_pop;

  // Hold the rotation order register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= e2q_pkg::ORD_XYZ;
    end else if (cfg_valid_i && cfg_ready_o) begin
      order_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Run the front end only while the queue has room
  assign front_en   = !q_stat.full;
  assign in_stall_o = !front_en;
  assign q_push     = front_en && front_valid;

  e2q_front #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (front_en),
    .in_valid_i (in_valid_i),
    .angle_x_i  (angle_x_i),
    .angle_y_i  (angle_y_i),
    .angle_z_i  (angle_z_i),
    .order_i    (order_q),
    .valid_o    (front_valid),
    .quat_o     (front_quat)
  );

  e2q_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (front_quat),
    .pop_i  (q_pop),
    .data_o (head_quat),
    .stat_o (q_stat)
  );

  e2q_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_stat.empty),
    .head_i       (head_quat),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .quat_x_o     (quat_x_o),
    .quat_y_o     (quat_y_o),
    .quat_z_o     (quat_z_o),
    .quat_w_o     (quat_w_o)
  );

  // Check queue bookkeeping against the handshakes
  `E2Q_ASSERT_SAME(a_pop_not_empty, q_pop, !q_stat.empty, "pop from empty queue")
  `E2Q_ASSERT_NEXT(a_full_stalls, q_stat.full && !q_pop, in_stall_o, "full queue not stalling")
  `E2Q_ASSERT_NEXT(a_empty_holds, q_stat.empty && !q_push, q_stat.empty, "queue filled w/o push")

endmodule
